[design/scpihr_pkg.sv]
// Package for the SCPI header recognizer: character codes, command and error codes,
// and the constant table of the 23 command patterns with their query forms.
// Used by scpi_header_recognizer; depends on nothing else.
package scpihr_pkg;

    // Character codes seen on the command line.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // Command identifiers that steer the error queue.
    localparam logic [4:0] CMD_UNDEFINED = 5'd0;
    localparam logic [4:0] CMD_CLS       = 5'd4;
    localparam logic [4:0] CMD_SYST_ERR  = 5'd6;

    // Error queue entry codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDEFINED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

    // Required query form of a pattern.
    localparam logic [1:0] Q_NO  = 2'd0;
    localparam logic [1:0] Q_YES = 2'd1;
    localparam logic [1:0] Q_ANY = 2'd2;

    localparam int PAT_COUNT = 23;
    localparam int PAT_LEN   = 26;

    typedef logic [4:0] pat_idx_t;
    typedef logic [PAT_LEN*8-1:0] pat_text_t;

    typedef struct packed {
        pat_text_t  text;
        logic [1:0] qmode;
    } pat_row_t;

    // Returns pattern idx (0-based) with its first character in the top byte and
    // zero bytes behind its last character, so that shifting left walks the text.
    function automatic pat_row_t pat_row(pat_idx_t idx);
        pat_row_t  r;
        pat_text_t s;
        int        n;
        s = '0;
        n = PAT_LEN;
        r.qmode = Q_NO;
        unique case (idx)
            5'd0:    begin s = "*IDN";                       n = 4;  r.qmode = Q_YES; end
            5'd1:    begin s = "*OPC";                       n = 4;  r.qmode = Q_YES; end
            5'd2:    begin s = "*RST";                       n = 4;  r.qmode = Q_NO;  end
            5'd3:    begin s = "*CLS";                       n = 4;  r.qmode = Q_NO;  end
            5'd4:    begin s = "SYSTem:VERSion";             n = 14; r.qmode = Q_YES; end
            5'd5:    begin s = "SYSTem:ERRor";               n = 12; r.qmode = Q_YES; end
            5'd6:    begin s = "SYSTem:TEMPerature";         n = 18; r.qmode = Q_YES; end
            5'd7:    begin s = "SYSTem:GPS:STATus";          n = 17; r.qmode = Q_YES; end
            5'd8:    begin s = "SYSTem:GPS:TIME";            n = 15; r.qmode = Q_YES; end
            5'd9:    begin s = "SYSTem:GPS:POSition";        n = 19; r.qmode = Q_YES; end
            5'd10:   begin s = "MEASure:FREQuency:DIV16";    n = 23; r.qmode = Q_YES; end
            5'd11:   begin s = "MEASure:FREQuency";          n = 17; r.qmode = Q_YES; end
            5'd12:   begin s = "CALCulate:DATA";             n = 14; r.qmode = Q_YES; end
            5'd13:   begin s = "CALCulate:LIMit:FAIL";       n = 20; r.qmode = Q_YES; end
            5'd14:   begin s = "CALCulate:MATH:STATe";       n = 20; r.qmode = Q_ANY; end
            5'd15:   begin s = "CALCulate:MATH:M";           n = 16; r.qmode = Q_ANY; end
            5'd16:   begin s = "CALCulate:MATH:B";           n = 16; r.qmode = Q_ANY; end
            5'd17:   begin s = "CALCulate:NULL:STATe";       n = 20; r.qmode = Q_ANY; end
            5'd18:   begin s = "CALCulate:LIMit:STATe";      n = 21; r.qmode = Q_ANY; end
            5'd19:   begin s = "CALCulate:LIMit:LOWer";      n = 21; r.qmode = Q_ANY; end
            5'd20:   begin s = "CALCulate:LIMit:UPPer";      n = 21; r.qmode = Q_ANY; end
            5'd21:   begin s = "STATus:OPERation:CONDition"; n = 26; r.qmode = Q_YES; end
            5'd22:   begin s = "CALCulate:NULL:ACQuire";     n = 22; r.qmode = Q_NO;  end
            default: begin s = '0;                           n = PAT_LEN; r.qmode = Q_NO; end
        endcase
        r.text = s << (8 * (PAT_LEN - n));
        return r;
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            u = c - CASE_DIFF;
        end
        return u;
    endfunction

endpackage

[design/scpihr_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used by scpi_header_recognizer for the header store.
module scpihr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 47
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/scpi_header_recognizer.sv]
// Top level of the SCPI command header recognizer.
// Depends on scpihr_pkg (pattern table, codes) and scpihr_ram (header store).
//
// Usage: command line bytes enter one word at a time on the slave stream
// (s_tdata = character, s_tlast = last byte of the line). Leading blanks are
// skipped and the header, up to HEADER_MAX characters, is kept in a small RAM.
// Bytes that do not end a line are accepted at once while the sequencer is idle.
// When the last byte of a line is taken, the input stops accepting words and a
// sequencer walks the 23 command patterns one after another, comparing one
// header character at a time (RAM read, then compare) with one shared case-folding
// comparator. A pattern takes a load step, then a fetch and a compare step per header
// character compared and a compare step per optional pattern character skipped; a
// wrong query form costs only the load step. The time until the result word is valid
// is set by the pattern walk, longest when every pattern is walked to its end.
// Exactly one result word per line leaves on the master stream: command_id,
// query_flag and, for SYSTem:ERRor?, the popped error queue entry. The result
// sits in an output register; bytes of the next line are accepted while it waits,
// but the next line end finishes only once the receiver has taken the earlier
// result. After reset the header and the error queue are empty and blanks are skipped.
module scpi_header_recognizer
    import scpihr_pkg::*;
#(
    parameter int HEADER_MAX  = 47,
    parameter int ERROR_DEPTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [4:0] command_id, [5] query_flag, [7:6] popped_error
);

    localparam int LEN_W  = $clog2(HEADER_MAX + 1);
    localparam int ADDR_W = $clog2(HEADER_MAX);
    localparam int HEAD_W = $clog2(ERROR_DEPTH);
    localparam int CNT_W  = $clog2(ERROR_DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * ERROR_DEPTH);

    // Line parsing phases.
    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_FULL = 2'd2;
    localparam logic [1:0] PH_REST = 2'd3;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             query_reg, query_next;
    logic [LEN_W-1:0] hp_reg, hp_next;
    pat_idx_t         pat_idx_reg, pat_idx_next;
    pat_text_t        text_reg, text_next;
    logic [4:0]       id_reg, id_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;

    logic [1:0]       err_entries_reg [ERROR_DEPTH];
    logic             err_wr_en;
    logic [HEAD_W-1:0] err_wr_idx;
    logic [1:0]       err_wr_code;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [7:0]        ram_rd_data;

    pat_row_t          row;
    logic [SUM_W-1:0]  tail_sum;
    logic [HEAD_W-1:0] tail_idx;
    logic [HEAD_W-1:0] newest_idx;
    logic [HEAD_W-1:0] head_inc;
    logic [LEN_W-1:0]  len_inc;

    scpihr_ram #(
        .WIDTH (8),
        .DEPTH (HEADER_MAX)
    ) u_header_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (len_reg[ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (hp_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign row      = pat_row(pat_idx_reg);
    assign len_inc  = len_reg + 1'b1;

    // Circular queue index arithmetic; the head stays below the depth and the count at most equals it.
    assign tail_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_idx   = (tail_sum >= SUM_W'(ERROR_DEPTH)) ?
                        HEAD_W'(tail_sum - SUM_W'(ERROR_DEPTH)) : HEAD_W'(tail_sum);
    assign newest_idx = (head_reg == '0) ? HEAD_W'(ERROR_DEPTH - 1) : head_reg - 1'b1;
    assign head_inc   = (head_reg == HEAD_W'(ERROR_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        logic       blank;
        logic [1:0] phase_eff;
        logic       miss;
        logic       qmode_ok;
        logic [7:0] hch;
        logic [7:0] pch;
        logic       h_end;
        logic       h_colon;
        logic       p_term;
        logic       p_lower;
        logic [1:0] popped;

        state_next     = state_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        query_next     = query_reg;
        hp_next        = hp_reg;
        pat_idx_next   = pat_idx_reg;
        text_next      = text_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        err_wr_en      = 1'b0;
        err_wr_idx     = tail_idx;
        err_wr_code    = ERR_UNDEFINED;
        miss           = 1'b0;
        popped         = ERR_NONE;

        blank     = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        phase_eff = (phase_reg == PH_SKIP && !blank) ? PH_HDR : phase_reg;
        qmode_ok  = (row.qmode == Q_ANY) ||
                    (row.qmode == Q_YES && query_reg) ||
                    (row.qmode == Q_NO && !query_reg);
        hch       = ram_rd_data;
        pch       = text_reg[PAT_LEN*8-1 -: 8];
        h_end     = (hp_reg == len_reg);
        h_colon   = !h_end && (hch == CH_COLON);
        p_term    = (pch == CH_NUL) || (pch == CH_COLON);
        p_lower   = (pch >= CH_LOWER_A) && (pch <= CH_LOWER_Z);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (phase_reg == PH_FULL)
                    begin
                        // Only a '?' right after a full header still counts.
                        if (s_tdata == CH_QUERY)
                        begin
                            query_next = 1'b1;
                        end
                        phase_next = PH_REST;
                    end
                    else if (phase_eff == PH_HDR)
                    begin
                        if (s_tdata == CH_NUL || blank)
                        begin
                            phase_next = PH_REST;
                        end
                        else if (s_tdata == CH_QUERY)
                        begin
                            query_next = 1'b1;
                            phase_next = PH_REST;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            len_next   = len_inc;
                            phase_next = (len_inc == LEN_W'(HEADER_MAX)) ? PH_FULL : PH_HDR;
                        end
                    end
                    if (s_tlast)
                    begin
                        pat_idx_next = '0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                text_next = row.text;
                hp_next   = '0;
                if (qmode_ok)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            ST_FETCH:
            begin
                ram_rd_en  = !h_end;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (h_end || h_colon)
                begin
                    // Header keyword is done: the pattern may still hold its
                    // optional lower-case tail, which is stepped over here.
                    if (p_lower)
                    begin
                        text_next = {text_reg[PAT_LEN*8-9:0], CH_NUL};
                    end
                    else if (h_end && pch == CH_NUL)
                    begin
                        id_next    = pat_idx_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (h_colon && pch == CH_COLON)
                    begin
                        hp_next    = hp_reg + 1'b1;
                        text_next  = {text_reg[PAT_LEN*8-9:0], CH_NUL};
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        miss = 1'b1;
                    end
                end
                else if (!p_term && to_upper(hch) == to_upper(pch))
                begin
                    hp_next    = hp_reg + 1'b1;
                    text_next  = {text_reg[PAT_LEN*8-9:0], CH_NUL};
                    state_next = ST_FETCH;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    if (id_reg == CMD_CLS)
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    else if (id_reg == CMD_SYST_ERR)
                    begin
                        if (count_reg != '0)
                        begin
                            popped     = err_entries_reg[head_reg];
                            head_next  = head_inc;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (id_reg == CMD_UNDEFINED)
                    begin
                        err_wr_en = 1'b1;
                        if (count_reg == CNT_W'(ERROR_DEPTH))
                        begin
                            // Full queue: the newest entry turns into overflow.
                            err_wr_idx  = newest_idx;
                            err_wr_code = ERR_OVERFLOW;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = {popped, query_reg, id_reg};
                    len_next       = '0;
                    phase_next     = PH_SKIP;
                    query_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (miss)
        begin
            if (pat_idx_reg == pat_idx_t'(PAT_COUNT - 1))
            begin
                id_next    = CMD_UNDEFINED;
                state_next = ST_DONE;
            end
            else
            begin
                pat_idx_next = pat_idx_reg + 1'b1;
                state_next   = ST_LOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_SKIP;
            len_reg       <= '0;
            query_reg     <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            query_reg     <= query_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hp_reg       <= hp_next;
        pat_idx_reg  <= pat_idx_next;
        text_reg     <= text_next;
        id_reg       <= id_next;
        out_data_reg <= out_data_next;
        if (err_wr_en)
        begin
            err_entries_reg[err_wr_idx] <= err_wr_code;
        end
    end

endmodule
